// File: rtl/core/midi_voice_allocator_macros.svh
// ---------------------------------------------------------------------------
// midi voice allocator assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef MIDI_VOICE_ALLOCATOR_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// checked on every edge out of reset
`define MVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define MVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MVA_ASSERT(lbl, prop, msg)
`define MVA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/mva_pkg.sv
// ---------------------------------------------------------------------------
// midi voice allocator package
// item types, chain token and update types, codes and the semitone table
// ---------------------------------------------------------------------------
package mva_pkg;

  // voice index width covering the largest supported voice count
  localparam int unsigned IDX_W = 6;

  // command codes
  localparam logic [1:0] CMD_NOTE_OFF = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;

  // action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_TRIGGER = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // lowest note of the frequency table (a0)
  localparam logic [6:0] A0_NOTE = 7'd21;

  // round(27.5 * 2^(k/12) * 2^16) for one octave
  localparam logic [21:0] SEMITONE_Q16 [12] = '{
    22'd1802240, 22'd1909407, 22'd2022946, 22'd2143237,
    22'd2270680, 22'd2405702, 22'd2548752, 22'd2700309,
    22'd2860878, 22'd3030994, 22'd3211227, 22'd3402176
  };

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  voice;
    logic [23:0] frequency;
    logic [6:0]  gain;
  } out_item_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [6:0]       note;
    logic             found;
    logic [IDX_W-1:0] match_idx;
    logic             has_free;
    logic [IDX_W-1:0] free_idx;
  } tok_t;

  // state write broadcast to all cells
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             busy;
    logic [6:0]       note;
  } upd_t;

endpackage

// File: rtl/core/mva_cell.sv
// ---------------------------------------------------------------------------
// midi voice allocator voice cell
// holds one voice's busy mark and note, updates the passing search token
// ---------------------------------------------------------------------------
module mva_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mva_pkg::tok_t tok_i,
  output mva_pkg::tok_t tok_o,
  input  mva_pkg::upd_t upd_i
);
  import mva_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic       busy_q;
  logic [6:0] note_q;
  tok_t       tok_d, tok_q;

  // first busy match wins, else remember the lowest free voice
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found) begin
      if (!busy_q) begin
        if (!tok_i.has_free) begin
          tok_d.has_free = 1'b1;
          tok_d.free_idx = MY_IDX;
        end
      end else if (note_q == tok_i.note) begin
        tok_d.found     = 1'b1;
        tok_d.match_idx = MY_IDX;
      end
    end
  end

  // token register towards the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      note_q <= 7'd0;
    end else if (upd_i.valid && (upd_i.idx == MY_IDX)) begin
      busy_q <= upd_i.busy;
      note_q <= upd_i.note;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/core/mva_pitch.sv
// ---------------------------------------------------------------------------
// midi voice allocator pitch
// equal-tempered note frequency in unsigned q14.10
// ---------------------------------------------------------------------------
module mva_pitch (
  input  logic [6:0]  note_i,
  output logic [23:0] freq_o
);
  import mva_pkg::*;

  logic [6:0]  delta;
  logic [12:0] prod;
  logic [3:0]  octave;
  logic [6:0]  rem_full;
  logic [3:0]  semi;
  logic [29:0] shifted;
  logic [29:0] rounded;

  // distance from a0, clamped at zero
  assign delta = (note_i <= A0_NOTE) ? 7'd0 : (note_i - A0_NOTE);

  // divide by twelve via reciprocal 43/512, exact for the note range
  assign prod     = {6'd0, delta} * 13'd43;
  assign octave   = prod[12:9];
  assign rem_full = delta - (7'({3'd0, octave}) * 7'd12);
  assign semi     = rem_full[3:0];

  // scale by octave and round half up from q.16 to q.10
  always_comb begin
    shifted = 30'd0;
    if (semi < 4'd12) begin
      shifted = {8'd0, SEMITONE_Q16[semi]} << octave;
    end
  end

  assign rounded = shifted + 30'd32;
  assign freq_o  = rounded[29:6];

endmodule

// File: rtl/core/midi_voice_allocator.sv
// ---------------------------------------------------------------------------
// midi voice allocator: each result passes the cell chain, then a pending register
// and the output register; input stalls while a scan runs or a result waits
// a search token walks the chain of voice cells, one cell per cycle
// reset (async, active low) frees every voice and clears all notes
// ---------------------------------------------------------------------------
`include "midi_voice_allocator_macros.svh"

module midi_voice_allocator #(
  parameter int unsigned VOICES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mva_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mva_pkg::out_item_t  out_item_o
);
  import mva_pkg::*;

  logic      accept;
  logic      scan_q;
  in_item_t  item_q;
  tok_t      tok [VOICES+1];
  tok_t      tok_end;
  upd_t      upd;
  logic      chosen_ok;
  logic [IDX_W-1:0] chosen_idx;
  logic [23:0] freq;
  out_item_t res;
  out_item_t pend_q, out_q;
  logic      pend_valid_q, out_valid_q;
  logic      out_free;

  // input handshake
  assign in_stall_o = scan_q | pend_valid_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // token entering the chain
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept;
    tok[0].note  = in_item_i.note;
  end

  // chain of voice cells
  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    mva_cell #(
      .INDEX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .upd_i  (upd)
    );
  end

  assign tok_end = tok[VOICES];

  mva_pitch u_pitch (
    .note_i (item_q.note),
    .freq_o (freq)
  );

  // decision once the token leaves the last cell
  assign chosen_ok  = tok_end.found | tok_end.has_free;
  assign chosen_idx = tok_end.found ? tok_end.match_idx : tok_end.free_idx;

  always_comb begin
    res = '0;
    if (chosen_ok && ((item_q.command == CMD_NOTE_OFF) || (item_q.command == CMD_NOTE_ON))) begin
      res.voice = chosen_idx[3:0];
      if ((item_q.command == CMD_NOTE_ON) && (item_q.velocity != 7'd0)) begin
        res.action    = ACT_TRIGGER;
        res.frequency = freq;
        res.gain      = item_q.velocity;
      end else begin
        res.action = ACT_RELEASE;
      end
    end
  end

  // state write back to the chosen cell
  always_comb begin
    upd       = '0;
    upd.valid = tok_end.valid && (res.action != ACT_NONE);
    upd.idx   = chosen_idx;
    upd.busy  = (res.action == ACT_TRIGGER);
    upd.note  = (res.action == ACT_TRIGGER) ? item_q.note : 7'd0;
  end

  // item capture and scan flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= 1'b0;
    end else if (accept) begin
      scan_q <= 1'b1;
    end else if (tok_end.valid) begin
      scan_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // pending result and output register
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (tok_end.valid) begin
        pend_valid_q <= 1'b1;
      end else if (pend_valid_q && out_free) begin
        pend_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= pend_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end.valid) begin
      pend_q <= res;
    end
    if (out_free && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `MVA_ASSERT(a_accept_starts_scan, accept |=> scan_q, "accepted item did not start a scan")
  `MVA_ASSERT_ALWAYS(a_scan_pend_excl, !(scan_q && pend_valid_q), "scan and pending overlap")
  `MVA_ASSERT(a_token_in_scan, tok_end.valid |-> scan_q, "token left chain outside a scan")
  `MVA_ASSERT(a_no_action_zero, out_valid_q && (out_q.action == ACT_NONE) |-> (out_q.voice == 4'd0) && (out_q.frequency == 24'd0), "no-action item has fields set")

endmodule

// File: verif/mva_voice_checker.sv
// ---------------------------------------------------------------------------
// midi voice allocator event checker
// watches both channels, predicts each allocation from its own copy of the
// voice table and compares every accepted result with the oldest prediction
// ---------------------------------------------------------------------------
module mva_voice_checker
  import mva_pkg::*;
#(
  parameter int unsigned VOICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned mismatch_o,
  output int unsigned pending_o,
  output int unsigned triggers_o,
  output int unsigned releases_o,
  output int unsigned idle_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  // one octave of a0-based pitches in q.16 hz
  localparam logic [21:0] OCTAVE_Q16 [12] = '{
    22'd1802240, 22'd1909407, 22'd2022946, 22'd2143237,
    22'd2270680, 22'd2405702, 22'd2548752, 22'd2700309,
    22'd2860878, 22'd3030994, 22'd3211227, 22'd3402176
  };

  // predicted voice table
  logic       held      [VOICES];
  logic [6:0] held_note [VOICES];

  out_item_t allocations_q [$];
  out_item_t want;

  // equal-tempered pitch in q14.10, everything at or below a0 pinned to a0
  function automatic logic [23:0] pitch_q10(logic [6:0] note);
    logic [6:0]  span;
    logic [3:0]  semi;
    logic [3:0]  octave;
    logic [63:0] scaled;
    span   = (note <= A0_NOTE) ? 7'd0 : note - A0_NOTE;
    semi   = 4'(span % 7'd12);
    octave = 4'(span / 7'd12);
    scaled = (64'(OCTAVE_Q16[semi]) << octave) + 64'd32;
    scaled = scaled >> 6;
    if (scaled > 64'hFF_FFFF) scaled = 64'hFF_FFFF;
    return scaled[23:0];
  endfunction

  // pick the voice holding the note, else the lowest free one, and apply the event
  function automatic out_item_t allocate_voice(in_item_t ev);
    int        pick;
    int        spare;
    out_item_t res;
    pick  = -1;
    spare = -1;
    res   = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (!held[v]) begin
        if (spare < 0) spare = v;
      end else if (held_note[v] == ev.note && pick < 0) begin
        pick = v;
      end
    end
    if (pick < 0) pick = spare;
    if (pick >= 0 && (ev.command == CMD_NOTE_OFF || ev.command == CMD_NOTE_ON)) begin
      if (ev.command == CMD_NOTE_ON && ev.velocity != 7'd0) begin
        held[pick]      = 1'b1;
        held_note[pick] = ev.note;
        res.action      = ACT_TRIGGER;
        res.frequency   = pitch_q10(ev.note);
        res.gain        = ev.velocity;
      end else begin
        held[pick]      = 1'b0;
        held_note[pick] = 7'd0;
        res.action      = ACT_RELEASE;
      end
      res.voice = 4'(pick);
    end
    return res;
  endfunction

  // compare first, then predict, so a stray result is never matched to its own item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        held[v]      = 1'b0;
        held_note[v] = 7'd0;
      end
      allocations_q.delete();
      mismatch_o = 0;
      pending_o  = 0;
      triggers_o = 0;
      releases_o = 0;
      idle_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (allocations_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= REPORT_LIMIT)
            $display("[%0t] unexpected item: action %0d voice %0d freq %0d gain %0d",
                     $realtime, out_item_i.action, out_item_i.voice,
                     out_item_i.frequency, out_item_i.gain);
        end else begin
          want = allocations_q.pop_front();
          case (want.action)
            ACT_TRIGGER: triggers_o++;
            ACT_RELEASE: releases_o++;
            default:     idle_o++;
          endcase
          if (out_item_i.action !== want.action || out_item_i.voice !== want.voice ||
              out_item_i.frequency !== want.frequency || out_item_i.gain !== want.gain) begin
            mismatch_o++;
            if (mismatch_o <= REPORT_LIMIT)
              $display({"[%0t] item mismatch: action %0d/%0d voice %0d/%0d ",
                        "freq %0d/%0d gain %0d/%0d (expected/actual)"},
                       $realtime, want.action, out_item_i.action, want.voice,
                       out_item_i.voice, want.frequency, out_item_i.frequency,
                       want.gain, out_item_i.gain);
          end
        end
      end
      if (in_valid_i && !in_stall_i) allocations_q.push_back(allocate_voice(in_item_i));
      pending_o = allocations_q.size();
    end
  end

endmodule

// File: verif/midi_voice_allocator_tb.sv
// ---------------------------------------------------------------------------
// midi voice allocator testbench
// directed voice-table corner cases followed by random note-on/note-off
// traffic over shifting note pools, with random gaps and output stalls
// ---------------------------------------------------------------------------
module midi_voice_allocator_tb;
  import mva_pkg::*;

  localparam int          CLK_PERIOD     = 12;
  localparam int          RESET_CYCLES   = 9;
  localparam int unsigned VOICES         = 16;
  localparam int unsigned MAX_WAIT       = 8;
  localparam int unsigned RANDOM_EVENTS  = 1300;
  localparam int unsigned BLOCK_EVENTS   = 100;
  localparam int unsigned HOLD_OFF       = 400;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int          TIMEOUT_CYCLES = 400000;

  // channel events the block ignores
  localparam logic [1:0] CMD_OTHER    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned triggers;
  int unsigned releases;
  int unsigned idles;
  int unsigned events_sent;
  bit          steady;

  midi_voice_allocator #(
    .VOICES (VOICES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  mva_voice_checker #(
    .VOICES (VOICES)
  ) voice_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .mismatch_o  (mismatches),
    .pending_o   (pending),
    .triggers_o  (triggers),
    .releases_o  (releases),
    .idle_o      (idles)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[%0t] timeout with %0d results outstanding", $realtime, pending);
    $display("midi_voice_allocator test failed");
    $finish;
  end

  // offer one item after a random gap and hold it until taken
  task automatic offer_event(in_item_t ev);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    do @(posedge clk_i); while (in_stall_o);
    events_sent++;
  endtask

  task automatic play(logic [1:0] cmd, logic [6:0] note, logic [6:0] vel);
    in_item_t ev;
    ev.command  = cmd;
    ev.note     = note;
    ev.velocity = vel;
    offer_event(ev);
  endtask

  // mostly notes from a narrow pool so voices get reused, some strays and noise
  function automatic in_item_t random_event(int unsigned on_bias, int unsigned base);
    in_item_t ev;
    ev.note     = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'(base + $urandom_range(0, 23));
    ev.velocity = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 5) begin
      ev.command = ($urandom_range(0, 1) == 0) ? CMD_OTHER : CMD_RESERVED;
    end else if ($urandom_range(0, 99) < on_bias) begin
      ev.command = CMD_NOTE_ON;
      if ($urandom_range(0, 9) == 0) ev.velocity = 7'd0;
    end else begin
      ev.command = CMD_NOTE_OFF;
    end
    return ev;
  endfunction

  // receiver: random stalls pressed on valid results, two long hold-offs
  initial begin
    int unsigned taken;
    int unsigned hold;
    taken = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken == 300 || taken == 900) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk_i);
      end else begin
        hold = steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          while (hold != 0) begin
            @(posedge clk_i);
            if (out_valid_o) hold--;
          end
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned counted;
    int unsigned on_bias;
    int unsigned base;
    int unsigned directed;
    int unsigned drain;
    in_item_t    ev;
    counted     = 0;
    drain       = 0;
    events_sent = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored events, then a note off that lands on a free voice
    play(CMD_OTHER, 7'd60, 7'd100);
    play(CMD_RESERVED, 7'd127, 7'd127);
    play(CMD_NOTE_OFF, 7'd50, 7'd0);
    // note extremes, a0 boundary and concert a
    play(CMD_NOTE_ON, 7'd0, 7'd127);
    play(CMD_NOTE_ON, 7'd127, 7'd1);
    play(CMD_NOTE_ON, 7'd21, 7'd64);
    play(CMD_NOTE_ON, 7'd69, 7'd127);
    // retrigger, then zero-velocity release of the same voice
    play(CMD_NOTE_ON, 7'd69, 7'd5);
    play(CMD_NOTE_ON, 7'd69, 7'd0);
    play(CMD_NOTE_ON, 7'd22, 7'd100);
    // fill the remaining voices
    for (int n = 30; n < 42; n++) play(CMD_NOTE_ON, 7'(n), 7'(n + 40));
    // all voices busy: unknown note on and note off both do nothing, then note 0 is released
    play(CMD_NOTE_ON, 7'd100, 7'd90);
    play(CMD_NOTE_OFF, 7'd101, 7'd33);
    play(CMD_NOTE_OFF, 7'd0, 7'd127);
    directed = events_sent;

    // random blocks alternating fill-up and drain-down bias
    for (int unsigned blk = 0; counted < RANDOM_EVENTS; blk++) begin
      steady  = ($urandom_range(0, 3) == 0);
      on_bias = (blk % 2 == 0) ? 70 : 35;
      base    = $urandom_range(0, 104);
      repeat (BLOCK_EVENTS) begin
        ev = random_event(on_bias, base);
        offer_event(ev);
        if (ev.command == CMD_NOTE_ON || ev.command == CMD_NOTE_OFF) counted++;
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d events (%0d directed) gave %0d triggers, %0d releases, %0d no-ops",
             events_sent, directed, triggers, releases, idles);
    $display("summary: %0d mismatches, %0d results missing, output held off twice for %0d cycles",
             mismatches, pending, HOLD_OFF);
    if (mismatches == 0 && pending == 0) begin
      $display("midi_voice_allocator test passed");
    end else begin
      $display("midi_voice_allocator test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mva_pkg.sv
rtl/core/mva_cell.sv
rtl/core/mva_pitch.sv
rtl/core/midi_voice_allocator.sv
verif/mva_voice_checker.sv
verif/midi_voice_allocator_tb.sv
